@@ hw/rtl/csg_pkg.sv @@
package csg_pkg;

    localparam int unsigned SINE_W      = 16;
    localparam int unsigned REG_W       = 12;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned SAMPLE_W    = 13;
    localparam int unsigned FRAC_BITS   = 15;

    localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET = 13'd150;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FULL_SCALE = 2'd0,
        CFG_DISTORTION = 2'd1,
        CFG_WAVE_MODE  = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAN       = 2'd0,
        MODE_TOP_CLIP    = 2'd1,
        MODE_BOTTOM_CLIP = 2'd2,
        MODE_BOTH_CLIP   = 2'd3
    } wave_mode_t;

    // Sine of a Q32 fraction of a turn as signed Q1.15. Evaluated at
    // elaboration only, to fill the sine table.
    function automatic logic signed [SINE_W-1:0] sine_q15(input logic [63:0] turn);
        logic [1:0]         quad;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [64:0] sum;
        logic [63:0]        mag;
        quad = turn[31:30];
        r    = {34'd0, turn[29:0]};
        if (quad[0])
        begin
            r = ONE_Q30 - r;
        end
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed({1'b0, x});
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed({1'b0, term});
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - $signed({1'b0, term});
        if (sum < 0)
        begin
            sum = '0;
        end
        if (sum > $signed({1'b0, ONE_Q30}))
        begin
            sum = $signed({1'b0, ONE_Q30});
        end
        mag = (sum[63:0] + 64'd16384) >> 15;
        if (mag > 64'd32767)
        begin
            mag = 64'd32767;
        end
        if (quad[1])
        begin
            return -$signed(mag[SINE_W-1:0]);
        end
        return $signed(mag[SINE_W-1:0]);
    endfunction

endpackage

@@ hw/rtl/csg_sine_rom.sv @@
module csg_sine_rom #(
    parameter int unsigned PERIOD_SAMPLES = 480,
    parameter int unsigned PHASE_W        = 9
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [PHASE_W-1:0]                   addr,
    output logic signed [csg_pkg::SINE_W-1:0]    data
);

    logic signed [csg_pkg::SINE_W-1:0] rom [PERIOD_SAMPLES];
    logic signed [csg_pkg::SINE_W-1:0] data_reg;

    // One entry per phase step: sin(2*pi*i/PERIOD_SAMPLES)
    for (genvar i = 0; i < PERIOD_SAMPLES; i++)
    begin : g_entry
        localparam logic [63:0] TURN = (64'(i) << 32) / PERIOD_SAMPLES;
        assign rom[i] = csg_pkg::sine_q15(TURN);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= rom[addr];
        end
    end

    assign data = data_reg;

endmodule

@@ hw/rtl/clipped_sine_wave_generator.sv @@
// Clipped sine wave generator: one DAC code per accepted item.
// Item channel (item_valid / item_stall / restart): each beat asks for one
// sample. restart=1 puts the phase back to zero before that sample;
// otherwise the phase advances by one and wraps after PERIOD_SAMPLES.
// Result channel (res_valid / res_stall / sample / period_end): one beat
// per item, in order. sample is the clamped wave plus 150; period_end
// marks the sample taken at the last phase of a period.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
// ready; index 0 full_scale, 1 distortion_level, 2 wave_mode, others are
// dropped. Write only while no sample is in flight.
// An item beat reaches res_valid through the stage-1, stage-2 and output
// registers; throughput is one sample per cycle while res_stall does not
// hold the output register. The pipeline is sine ROM read, one multiply,
// then the add-and-clamp into the output register.
// The pipeline advances whenever the output register is empty or drained,
// so item_stall follows res_stall only while a result is held.
// Reset clears the phase, all valid flags and restores the register
// defaults (3500, 700, clean).
module clipped_sine_wave_generator #(
    parameter int unsigned PERIOD_SAMPLES = 480
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic                              restart,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [csg_pkg::SAMPLE_W-1:0]      sample,
    output logic                              period_end,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [csg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [csg_pkg::REG_W-1:0]         cfg_data
);

    localparam int unsigned        PHASE_W    = $clog2(PERIOD_SAMPLES);
    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(PERIOD_SAMPLES - 1);

    // Configuration registers
    logic [csg_pkg::REG_W-1:0]  full_scale_reg;
    logic [csg_pkg::REG_W-1:0]  distortion_reg;
    csg_pkg::wave_mode_t        wave_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= 12'd3500;
            distortion_reg <= 12'd700;
            wave_mode_reg  <= csg_pkg::MODE_CLEAN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (csg_pkg::cfg_index_t'(cfg_index))
                csg_pkg::CFG_FULL_SCALE: full_scale_reg <= cfg_data;
                csg_pkg::CFG_DISTORTION: distortion_reg <= cfg_data;
                csg_pkg::CFG_WAVE_MODE:
                    wave_mode_reg <= csg_pkg::wave_mode_t'(cfg_data[csg_pkg::MODE_W-1:0]);
                default: ;
            endcase
        end
    end

    // Pipeline advance: move every stage when the output register can load
    logic res_valid_reg;
    logic adv;
    logic item_beat;

    assign adv        = !res_valid_reg || !res_stall;
    assign item_stall = !adv;
    assign item_beat  = item_valid && !item_stall;

    // Phase counter
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] idx;
    logic [PHASE_W-1:0] phase_next;

    always_comb
    begin
        idx        = restart ? '0 : phase_reg;
        phase_next = (idx == LAST_PHASE) ? '0 : idx + PHASE_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (item_beat)
        begin
            phase_reg <= phase_next;
        end
    end

    // Stage 1: sine lookup, offset and amplitude from the registers
    logic                              s1_valid_reg;
    logic                              s1_last_reg;
    logic signed [csg_pkg::SINE_W-1:0] sine;
    logic signed [13:0]                c_next;
    logic signed [13:0]                a_next;
    logic signed [13:0]                s1_c_reg;
    logic signed [13:0]                s1_a_reg;
    logic [12:0]                       s1_top_reg;
    logic [12:0]                       fs_plus1;
    logic signed [13:0]                h;
    logic signed [13:0]                v;
    logic signed [13:0]                vh;

    csg_sine_rom #(
        .PERIOD_SAMPLES (PERIOD_SAMPLES),
        .PHASE_W        (PHASE_W)
    ) u_rom (
        .clk  (clk),
        .en   (adv),
        .addr (idx),
        .data (sine)
    );

    always_comb
    begin
        fs_plus1 = {1'b0, full_scale_reg} + 13'd1;
        h        = $signed({2'b00, fs_plus1[12:1]});
        v        = $signed({2'b00, distortion_reg});
        vh       = $signed({3'b000, distortion_reg[11:1]});
        case (wave_mode_reg)
            csg_pkg::MODE_TOP_CLIP:
            begin
                c_next = h + vh;
                a_next = h + vh;
            end
            csg_pkg::MODE_BOTTOM_CLIP:
            begin
                c_next = h - vh;
                a_next = h + vh;
            end
            csg_pkg::MODE_BOTH_CLIP:
            begin
                c_next = h;
                a_next = h + v;
            end
            default:
            begin
                c_next = h;
                a_next = h;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= item_beat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_last_reg <= (idx == LAST_PHASE);
            s1_c_reg    <= c_next;
            s1_a_reg    <= a_next;
            s1_top_reg  <= fs_plus1;
        end
    end

    // Stage 2: amplitude times sine
    logic               s2_valid_reg;
    logic               s2_last_reg;
    logic signed [29:0] s2_prod_reg;
    logic signed [13:0] s2_c_reg;
    logic [12:0]        s2_top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_last_reg <= s1_last_reg;
            s2_prod_reg <= 30'(s1_a_reg * sine);
            s2_c_reg    <= s1_c_reg;
            s2_top_reg  <= s1_top_reg;
        end
    end

    // Stage 3: add offset, clamp to [0, full_scale+1], drop fraction, add 150
    logic signed [31:0]           y;
    logic signed [31:0]           top;
    logic [12:0]                  y_int;
    logic [csg_pkg::SAMPLE_W-1:0] sample_next;
    logic [csg_pkg::SAMPLE_W-1:0] sample_reg;
    logic                         period_end_reg;

    always_comb
    begin
        y   = (32'(s2_c_reg) <<< csg_pkg::FRAC_BITS) + 32'(s2_prod_reg);
        top = $signed({4'd0, s2_top_reg, 15'd0});
        if (y > top)
        begin
            y = top;
        end
        if (y < 0)
        begin
            y = '0;
        end
        y_int       = y[27:15];
        sample_next = y_int + csg_pkg::SAMPLE_OFFSET;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sample_reg     <= sample_next;
            period_end_reg <= s2_last_reg;
        end
    end

    assign res_valid  = res_valid_reg;
    assign sample     = sample_reg;
    assign period_end = period_end_reg;

    // Phase never leaves its period
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= LAST_PHASE)
        else $error("phase counter out of range");

    // Wrap at the end of a period
    a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        item_beat && !restart && phase_reg == LAST_PHASE |=> phase_reg == '0)
        else $error("phase did not wrap");

    // Output code stays within offset range
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (sample >= 13'd150) && (sample <= 13'd4246))
        else $error("sample out of range");

    // A restart beat produces phase one next when the period has more than one sample
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        item_beat && restart && PERIOD_SAMPLES > 1 |=> phase_reg == PHASE_W'(1))
        else $error("restart did not reset phase");

endmodule

@@ dv/clipped_sine_wave_generator_tb.sv @@
module clipped_sine_wave_generator_tb;

    localparam int unsigned PERIOD_SAMPLES = 480;
    // Drain wait before a register write; covers the three pipeline stages.
    localparam int unsigned DRAIN_CYCLES   = 4;
    // Cycles with no beat on any channel before the run is declared hung.
    localparam int unsigned QUIET_LIMIT    = 1000;
    localparam int unsigned ITEMS_PER_SET  = 78;
    localparam int unsigned RANDOM_SETS    = 12;
    localparam longint unsigned HALF_PI_RAD_Q30 = 64'd1686629713;
    localparam longint unsigned UNIT_Q30        = 64'd1073741824;
    localparam longint DAC_OFFSET               = 150;

    // One result beat as seen on the output ports.
    typedef struct packed {
        logic [csg_pkg::SAMPLE_W-1:0] sample;
        logic                         period_end;
    } dac_beat_t;

    // Scoreboard: keeps a shadow of the registers and the phase counter,
    // predicts the DAC code for every accepted item and matches results
    // against the oldest prediction.
    class dac_code_scoreboard;
        logic signed [csg_pkg::SINE_W-1:0] sine_rom [PERIOD_SAMPLES];
        logic [csg_pkg::REG_W-1:0]         full_scale;
        logic [csg_pkg::REG_W-1:0]         distortion;
        csg_pkg::wave_mode_t               mode;
        int unsigned                       phase;
        dac_beat_t                         expected_codes[$];
        int unsigned                       mismatches;

        function new();
            full_scale = csg_pkg::REG_W'(3500);
            distortion = csg_pkg::REG_W'(700);
            mode       = csg_pkg::MODE_CLEAN;
            phase      = 0;
            mismatches = 0;
            for (int unsigned i = 0; i < PERIOD_SAMPLES; i++)
            begin
                sine_rom[i] = csg_pkg::SINE_W'(table_sine(i));
            end
        endfunction

        // Sine of step idx of the period in Q1.15: fold the turn into the
        // first quadrant, sum the Taylor series in Q30, round and saturate.
        function int table_sine(int unsigned idx);
            longint unsigned turn;
            longint unsigned r;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint unsigned mag;
            longint          sum;
            int unsigned     quadrant;
            turn     = idx;
            turn     = (turn << 32) / PERIOD_SAMPLES;
            quadrant = int'((turn >> 30) & 64'd3);
            r        = turn & (UNIT_Q30 - 1);
            if (quadrant[0])
            begin
                r = UNIT_Q30 - r;
            end
            x    = (r * HALF_PI_RAD_Q30) >> 30;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int unsigned k = 1; k <= 7; k++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k[0])
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            if (sum > longint'(UNIT_Q30))
            begin
                sum = longint'(UNIT_Q30);
            end
            mag = (longint'(sum) + 16384) >> 15;
            if (mag > 32767)
            begin
                mag = 32767;
            end
            return (quadrant >= 2) ? -int'(mag) : int'(mag);
        endfunction

        // Register beat: indexes past the mode register are dropped.
        function void write_reg(csg_pkg::cfg_index_t idx, logic [csg_pkg::REG_W-1:0] data);
            case (idx)
                csg_pkg::CFG_FULL_SCALE: full_scale = data;
                csg_pkg::CFG_DISTORTION: distortion = data;
                csg_pkg::CFG_WAVE_MODE:
                    mode = csg_pkg::wave_mode_t'(data[csg_pkg::MODE_W-1:0]);
                default:        ;
            endcase
        endfunction

        // Offset plus amplitude times sine, clamped to the span, then offset.
        function dac_beat_t predict_dac_code(int unsigned idx);
            longint    h;
            longint    v;
            longint    vh;
            longint    center;
            longint    amp;
            longint    y;
            longint    ceiling;
            dac_beat_t code;
            h  = (longint'(full_scale) + 1) >> 1;
            v  = longint'(distortion);
            vh = longint'(distortion) >> 1;
            case (mode)
                csg_pkg::MODE_TOP_CLIP:
                begin
                    center = h + vh;
                    amp    = h + vh;
                end
                csg_pkg::MODE_BOTTOM_CLIP:
                begin
                    center = h - vh;
                    amp    = h + vh;
                end
                csg_pkg::MODE_BOTH_CLIP:
                begin
                    center = h;
                    amp    = h + v;
                end
                default:
                begin
                    center = h;
                    amp    = h;
                end
            endcase
            y       = center * 32768 + amp * longint'(sine_rom[idx]);
            ceiling = (longint'(full_scale) + 1) * 32768;
            if (y > ceiling)
            begin
                y = ceiling;
            end
            if (y < 0)
            begin
                y = 0;
            end
            code.sample     = csg_pkg::SAMPLE_W'((y >> 15) + DAC_OFFSET);
            code.period_end = (idx == PERIOD_SAMPLES - 1);
            return code;
        endfunction

        // Input beat: restart pulls the phase back to zero for this sample.
        function void note_item(logic restart_bit);
            int unsigned idx;
            if (restart_bit)
            begin
                phase = 0;
            end
            idx = phase;
            expected_codes.push_back(predict_dac_code(idx));
            phase = (idx + 1 >= PERIOD_SAMPLES) ? 0 : idx + 1;
        endfunction

        function void check_result(logic [csg_pkg::SAMPLE_W-1:0] got_sample, logic got_end);
            dac_beat_t want;
            if (expected_codes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result beat: sample=%0d period_end=%0b",
                             got_sample, got_end);
                end
                return;
            end
            want = expected_codes.pop_front();
            if (want.sample !== got_sample || want.period_end !== got_end)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display({"result mismatch: expected sample=%0d period_end=%0b,",
                              " got sample=%0d period_end=%0b"},
                             want.sample, want.period_end, got_sample, got_end);
                end
            end
        endfunction
    endclass

    logic                            clk        = 1'b0;
    logic                            rst_n      = 1'b0;
    logic                            item_valid = 1'b0;
    logic                            item_stall;
    logic                            restart    = 1'b0;
    logic                            res_valid;
    logic                            res_stall  = 1'b0;
    logic [csg_pkg::SAMPLE_W-1:0]    sample;
    logic                            period_end;
    logic                            cfg_valid  = 1'b0;
    logic                            cfg_ready;
    logic [csg_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [csg_pkg::REG_W-1:0]       cfg_data   = '0;

    // Percent of cycles in which the sender holds back and the receiver stalls.
    int unsigned            send_idle_pct;
    int unsigned            stall_pct;

    dac_code_scoreboard     sb;

    clipped_sine_wave_generator #(
        .PERIOD_SAMPLES (PERIOD_SAMPLES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .restart    (restart),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .sample     (sample),
        .period_end (period_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: draw a fresh stall every cycle, independent of res_valid.
    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(99) < stall_pct);
    end

    // Monitor: every channel is sampled at the rising edge, before any of
    // the edge's updates land, so the scoreboard sees exactly the beats
    // the block saw.
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            sb.write_reg(csg_pkg::cfg_index_t'(cfg_index), cfg_data);
        end
        if (rst_n && item_valid && !item_stall)
        begin
            sb.note_item(restart);
        end
        if (rst_n && res_valid && !res_stall)
        begin
            sb.check_result(sample, period_end);
        end
    end

    // Watchdog: any beat on any channel resets the count of quiet cycles.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_valid && !item_stall) || (res_valid && !res_stall)
                || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("** clipped_sine_wave_generator: FAILED **");
        $finish;
    end

    // Offer one item beat. Drop valid only while idling, so a valid that
    // stays high between beats never sees a low and a high in one step.
    task automatic send_item(input logic restart_bit);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            restart    <= $urandom_range(1);
            @(posedge clk);
        end
        item_valid <= 1'b1;
        restart    <= restart_bit;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Hold cfg_valid across back-to-back beats; the caller drops it.
    task automatic cfg_beat(input csg_pkg::cfg_index_t idx,
                            input logic [csg_pkg::REG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Write all three registers, with an optional beat to the unused index
    // that the block must drop. The mode beat carries junk in the upper
    // data bits, which the block must mask off.
    task automatic load_wave_regs(input logic [csg_pkg::REG_W-1:0] fs,
                                  input logic [csg_pkg::REG_W-1:0] dist_lvl,
                                  input csg_pkg::wave_mode_t mode, input bit junk);
        cfg_beat(csg_pkg::CFG_FULL_SCALE, fs);
        cfg_beat(csg_pkg::CFG_DISTORTION, dist_lvl);
        if (junk)
        begin
            cfg_beat(csg_pkg::CFG_UNUSED, csg_pkg::REG_W'($urandom));
        end
        cfg_beat(csg_pkg::CFG_WAVE_MODE,
                 {(csg_pkg::REG_W - csg_pkg::MODE_W)'($urandom), mode});
        cfg_valid <= 1'b0;
    endtask

    // Stop sending, let every predicted code come back, then let the
    // pipeline go quiet before the registers are touched.
    task automatic wait_for_drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_codes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [csg_pkg::REG_W-1:0] fs;
        logic [csg_pkg::REG_W-1:0] dist_lvl;
        csg_pkg::wave_mode_t       mode;
        sb            = new();
        send_idle_pct = 35;
        stall_pct     = 47;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: first sample at phase zero, then restarts alone,
        // mid-stream and back to back.
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b1);
        send_item(1'b0);

        // Each clipped mode at the reset span and distortion.
        for (int m = 1; m < 4; m++)
        begin
            wait_for_drain();
            load_wave_regs(csg_pkg::REG_W'(3500), csg_pkg::REG_W'(700),
                           csg_pkg::wave_mode_t'(m), 1'b0);
            repeat (3) send_item(1'b0);
        end

        // Extremes: bottom clip at full span and distortion (center 1), then a zero span.
        wait_for_drain();
        load_wave_regs('1, '1, csg_pkg::MODE_BOTTOM_CLIP, 1'b1);
        send_item(1'b0);
        send_item(1'b0);
        wait_for_drain();
        load_wave_regs('0, '0, csg_pkg::MODE_CLEAN, 1'b1);
        send_item(1'b0);
        send_item(1'b0);

        // Random part: a register setting per set, restarts rare enough that
        // the phase runs through whole periods and wraps.
        for (int unsigned set_no = 0; set_no < RANDOM_SETS; set_no++)
        begin
            if (set_no == 4)
            begin
                send_idle_pct = 47;
                stall_pct     = 35;
            end
            else if (set_no == 8)
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            case (set_no)
                0:
                begin
                    fs = '1; dist_lvl = '0; mode = csg_pkg::MODE_CLEAN;
                end
                1:
                begin
                    fs = '0; dist_lvl = '1; mode = csg_pkg::MODE_TOP_CLIP;
                end
                2:
                begin
                    fs = '1; dist_lvl = '1; mode = csg_pkg::MODE_BOTH_CLIP;
                end
                5:
                begin
                    fs = '1; dist_lvl = '1; mode = csg_pkg::MODE_TOP_CLIP;
                end
                9:
                begin
                    fs = '0; dist_lvl = '0; mode = csg_pkg::MODE_BOTTOM_CLIP;
                end
                default:
                begin
                    fs       = csg_pkg::REG_W'($urandom);
                    dist_lvl = csg_pkg::REG_W'($urandom);
                    mode     = csg_pkg::wave_mode_t'($urandom_range(3));
                end
            endcase
            wait_for_drain();
            load_wave_regs(fs, dist_lvl, mode, bit'($urandom_range(1)));
            repeat (ITEMS_PER_SET) send_item($urandom_range(499) == 0);
        end

        wait_for_drain();
        if (sb.mismatches == 0 && sb.expected_codes.size() == 0)
        begin
            $display("** clipped_sine_wave_generator: PASSED **");
        end
        else
        begin
            $display("** clipped_sine_wave_generator: FAILED **");
        end
        $finish;
    end

endmodule
